// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define FSTG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define FSTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fstg_pkg.sv
package fstg_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int FREQ_W     = 16;
  localparam int AMP_W      = 16;
  localparam int LEN_W      = 32;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;

  // bit-serial arithmetic units
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 32;
  localparam int DIV_N_W   = 64;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_D_W   = 18;
  localparam int DIV_CNT_W = 7;

  // sine evaluation
  localparam int ENV_W    = 17;
  localparam int IDX_W    = 17;
  localparam int J_W      = 15;
  localparam int X_W      = 31;
  localparam int X2_W     = 32;
  localparam int T_W      = 31;
  localparam int ANGLE_W  = 46;
  localparam int Q30_SH   = 30;
  localparam int ROM_SH   = 14;
  localparam int TERM_K_W = 3;
  localparam int MAG_LSB  = 48;

  localparam logic [ENV_W-1:0]    ENV_ONE     = 17'h10000;
  localparam logic [T_W-1:0]      Q30_ONE     = 31'h4000_0000;
  localparam logic [MUL_A_W-1:0]  Q30_HALF_PI = 64'd1686629713;
  localparam logic [X2_W-1:0]     ROM_ROUND   = 32'd8192;
  localparam logic [TERM_K_W-1:0] TERM_LAST   = 3'd4;
  localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'h8000;

  typedef enum logic [1:0] {
    REG_FREQ = 2'd0,
    REG_AMP  = 2'd1,
    REG_LEN  = 2'd2,
    REG_FADE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOTAL,
    S_PHINC,
    S_INDEX,
    S_ANGLE_MUL,
    S_ANGLE_DIV,
    S_SQUARE,
    S_TERM_DIV,
    S_TERM_MUL,
    S_SINE,
    S_AMP,
    S_ENV,
    S_SCALE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Horner divisors of the sine series, innermost first
  function automatic logic [DIV_D_W-1:0] term_den(input logic [TERM_K_W-1:0] k);
    logic [DIV_D_W-1:0] d;
    unique case (k)
      3'd0:    d = 18'd110;
      3'd1:    d = 18'd72;
      3'd2:    d = 18'd42;
      3'd3:    d = 18'd20;
      default: d = 18'd6;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/fstg_in_if.sv
interface fstg_in_if;
  logic valid;
  logic ready;
  logic start_tone;

  modport source (output valid, output start_tone, input ready);
  modport sink (input valid, input start_tone, output ready);
endinterface

// File: rtl/fstg_out_if.sv
interface fstg_out_if;
  import fstg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_of_tone;

  modport source (output valid, output sample_value, output last_of_tone, input ready);
  modport sink (input valid, input sample_value, input last_of_tone, output ready);
endinterface

// File: rtl/fstg_cfg_if.sv
interface fstg_cfg_if;
  import fstg_pkg::*;

  logic                  valid;
  logic                  ready;
  cfg_idx_t              idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// File: rtl/fstg_ser_mul.sv
module fstg_ser_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fstg_pkg::MUL_A_W-1:0]   a,
  input  logic [fstg_pkg::MUL_B_W-1:0]   b,
  output logic [fstg_pkg::MUL_A_W-1:0]   prod,
  output fstg_pkg::unit_sts_t            sts
);
  import fstg_pkg::*;

  logic               run_r, run_nxt;
  logic [MUL_A_W-1:0] a_r, a_nxt;
  logic [MUL_B_W-1:0] b_r, b_nxt;
  logic [MUL_A_W-1:0] acc_r, acc_nxt;

  // shift-add, one multiplier bit a cycle; stop once no set bit is left
  always_comb begin
    run_nxt = run_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    if (start) begin
      run_nxt = 1'b1;
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = '0;
    end else if (run_r) begin
      if (b_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign prod     = acc_r;
  assign sts.busy = run_r;
  assign sts.done = run_r && (b_r == '0);

endmodule

// File: rtl/fstg_ser_div.sv
module fstg_ser_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [fstg_pkg::DIV_N_W-1:0]     num,
  input  logic [fstg_pkg::DIV_CNT_W-1:0]   steps,
  input  logic [fstg_pkg::DIV_D_W-1:0]     den,
  output logic [fstg_pkg::DIV_Q_W-1:0]     quo,
  output fstg_pkg::unit_sts_t              sts
);
  import fstg_pkg::*;

  logic                 run_r, run_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   num_r, num_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   den_r, den_nxt;
  logic [DIV_Q_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  // restoring division: the dividend arrives top-aligned, one bit a cycle
  assign trial = {rem_r, num_r[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    quo_nxt = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = steps;
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      quo_nxt = '0;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        rem_nxt = fits ? DIV_D_W'(trial - {1'b0, den_r}) : trial[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_Q_W-2:0], fits};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo      = quo_r;
  assign sts.busy = run_r;
  assign sts.done = run_r && (cnt_r == '0);

endmodule

// File: rtl/faded_sine_tone_generator.sv
// Sine tone generator with optional linear fade in and fade out.
// cfg_chan writes tone_frequency, tone_amplitude, tone_length and fade_enable
// (index 0 to 3); cfg_chan.ready is always high. Write it only while idle.
// Every word on in_chan is one sample tick. start_tone = 1 begins a new tone
// (restarting any running one), 0 continues. While a tone runs a tick yields
// one word on out_chan: sample_value and last_of_tone; an idle tick yields none.
// The phase accumulator keeps running across tones.
// Each running tick is worked off by one bit-serial multiplier (stepping through
// the multiplier bits up to the top set bit) and one bit-serial divider (stepping
// through the dividend bits) in turn: 12 multiplies and 7 divides, each with a
// start and a finish step. The word turns valid and in_chan.ready rises at the
// same edge. An idle tick runs only the sample-count multiply.
// in_chan.ready is high only while no tick is in work. A finished word sits in
// the output register; the next tick is accepted and computed while it waits,
// and that tick's word holds in its last step until the register frees.
// Reset (synchronous, rst_n low) clears the config registers, the phase, the counter,
// the envelope and any pending output word; no clearing pass is needed.
`include "assert_macros.svh"

module faded_sine_tone_generator #(
  parameter int SAMPLE_RATE_HZ   = 48000,
  parameter int SAMPLES_PER_MS   = 48,
  parameter int FADE_SAMPLES     = 256,
  parameter int MAX_AMPLITUDE    = 32767,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  fstg_cfg_if.sink     cfg_chan,
  fstg_in_if.sink      in_chan,
  fstg_out_if.source   out_chan
);
  import fstg_pkg::*;

  localparam logic [DIV_D_W-1:0] RATE_DEN   = DIV_D_W'(SAMPLE_RATE_HZ);
  localparam logic [DIV_D_W-1:0] DEPTH_DEN  = DIV_D_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   QUAD_1     = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   QUAD_2     = IDX_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   QUAD_3     = IDX_W'(3 * SINE_TABLE_DEPTH);
  localparam logic [MUL_B_W-1:0] QUAD_SCALE = MUL_B_W'(4 * SINE_TABLE_DEPTH);
  localparam logic [J_W-1:0]     DEPTH_J    = J_W'(SINE_TABLE_DEPTH);
  localparam logic [ENV_W-1:0]   ENV_STEP   = ENV_W'(65536 / FADE_SAMPLES);
  localparam logic [LEN_W:0]     FADE_LEN   = (LEN_W+1)'(FADE_SAMPLES);
  localparam logic [MUL_B_W-1:0] MS_MULT    = MUL_B_W'(SAMPLES_PER_MS);
  localparam logic [MUL_B_W-1:0] MAX_MULT   = MUL_B_W'(MAX_AMPLITUDE);

  state_t state_r, state_nxt;
  logic   kick_r, kick_nxt;

  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic [AMP_W-1:0]   amp_r, amp_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               fade_r, fade_nxt;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [ENV_W-1:0]   env_r, env_nxt;
  logic               active_r, active_nxt;

  logic                start_r, start_nxt;
  logic [LEN_W-1:0]    total_r, total_nxt;
  logic [J_W-1:0]      j_r, j_nxt;
  logic                neg_r, neg_nxt;
  logic [X_W-1:0]      x_r, x_nxt;
  logic [X2_W-1:0]     x2_r, x2_nxt;
  logic [X2_W-1:0]     dvd_r, dvd_nxt;
  logic [T_W-1:0]      t_r, t_nxt;
  logic [ENV_W-1:0]    rom_r, rom_nxt;
  logic [TERM_K_W-1:0] term_k_r, term_k_nxt;
  logic [SAMPLE_W-1:0] mag_r, mag_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_free;

  logic                 mul_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_A_W-1:0]   mul_prod;
  unit_sts_t            mul_sts;
  logic                 div_start;
  logic [DIV_N_W-1:0]   div_num;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_D_W-1:0]   div_den;
  logic [DIV_Q_W-1:0]   div_quo;
  unit_sts_t            div_sts;

  logic [LEN_W-1:0]    total_calc;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    off;
  logic [1:0]          quad;
  logic [J_W-1:0]      j_calc;
  logic [X2_W-1:0]     rom_sum;
  logic [ENV_W:0]      rom_q;
  logic [ENV_W-1:0]    rom_calc;
  logic [SAMPLE_W-1:0] neg_mag;
  logic [SAMPLE_W-1:0] sample_bits;
  logic [ENV_W:0]      env_up;
  logic [ENV_W-1:0]    env_rise;
  logic [ENV_W-1:0]    env_fall;
  logic [ENV_W-1:0]    env_calc;
  logic [LEN_W:0]      cnt_ext;
  logic [LEN_W:0]      total_ext;
  logic                last_calc;

  fstg_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  fstg_ser_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .steps (div_steps),
    .den   (div_den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  // saturate the sample count to 32 bits
  assign total_calc = (mul_prod[MUL_A_W-1:LEN_W] != '0) ? '1 : mul_prod[LEN_W-1:0];

  // fold the full-wave index into quarter and mirrored offset
  assign idx = mul_prod[PHASE_W+IDX_W-1:PHASE_W];
  always_comb begin
    if (idx >= QUAD_3) begin
      quad = 2'd3;
      off  = idx - QUAD_3;
    end else if (idx >= QUAD_2) begin
      quad = 2'd2;
      off  = idx - QUAD_2;
    end else if (idx >= QUAD_1) begin
      quad = 2'd1;
      off  = idx - QUAD_1;
    end else begin
      quad = 2'd0;
      off  = idx;
    end
    j_calc = quad[0] ? DEPTH_J - off[J_W-1:0] : off[J_W-1:0];
  end

  // round the Q30 sine to Q16 and clamp at unity
  assign rom_sum  = X2_W'(mul_prod[Q30_SH+X_W-1:Q30_SH]) + ROM_ROUND;
  assign rom_q    = rom_sum[X2_W-1:ROM_SH];
  assign rom_calc = (rom_q > {1'b0, ENV_ONE}) ? ENV_ONE : rom_q[ENV_W-1:0];

  always_comb begin
    neg_mag = (mag_r > SAMPLE_NEG_MAX) ? SAMPLE_NEG_MAX : mag_r;
    if (neg_r) begin
      sample_bits = (~neg_mag) + 1'b1;
    end else begin
      sample_bits = (mag_r > SAMPLE_POS_MAX) ? SAMPLE_POS_MAX : mag_r;
    end
  end

  // envelope and end-of-tone for the sample in hand
  assign cnt_ext   = {1'b0, cnt_r};
  assign total_ext = {1'b0, total_r};
  assign env_up    = {1'b0, env_r} + {1'b0, ENV_STEP};
  assign env_rise  = (env_up > {1'b0, ENV_ONE}) ? ENV_ONE : env_up[ENV_W-1:0];
  assign env_fall  = (env_r < ENV_STEP) ? '0 : env_r - ENV_STEP;
  assign last_calc = (cnt_ext + 1'b1) >= total_ext;
  always_comb begin
    if (cnt_ext < FADE_LEN) begin
      env_calc = env_rise;
    end else if ((cnt_ext + FADE_LEN) > total_ext) begin
      env_calc = env_fall;
    end else begin
      env_calc = ENV_ONE;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    kick_nxt       = 1'b0;
    freq_nxt       = freq_r;
    amp_nxt        = amp_r;
    len_nxt        = len_r;
    fade_nxt       = fade_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    env_nxt        = env_r;
    active_nxt     = active_r;
    start_nxt      = start_r;
    total_nxt      = total_r;
    j_nxt          = j_r;
    neg_nxt        = neg_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    dvd_nxt        = dvd_r;
    t_nxt          = t_r;
    rom_nxt        = rom_r;
    term_k_nxt     = term_k_r;
    mag_nxt        = mag_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_steps      = '0;
    div_den        = RATE_DEN;

    if (cfg_chan.valid) begin
      unique case (cfg_chan.idx)
        REG_FREQ: freq_nxt = cfg_chan.data[FREQ_W-1:0];
        REG_AMP:  amp_nxt  = cfg_chan.data[AMP_W-1:0];
        REG_LEN:  len_nxt  = cfg_chan.data[LEN_W-1:0];
        REG_FADE: fade_nxt = cfg_chan.data[0];
        default:  ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          start_nxt = in_chan.start_tone;
          state_nxt = S_TOTAL;
          kick_nxt  = 1'b1;
        end
      end
      S_TOTAL: begin
        mul_start = kick_r;
        mul_a     = MUL_A_W'(len_r);
        mul_b     = fade_r ? MS_MULT : MUL_B_W'(1);
        if (mul_sts.done) begin
          total_nxt = total_calc;
          if (start_r) begin
            cnt_nxt    = '0;
            env_nxt    = '0;
            active_nxt = total_calc != '0;
          end
          if (start_r ? (total_calc != '0) : active_r) begin
            state_nxt = S_PHINC;
            kick_nxt  = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PHINC: begin
        div_start = kick_r;
        div_num   = {freq_r, {(DIV_N_W-FREQ_W){1'b0}}};
        div_steps = DIV_CNT_W'(DIV_N_W - FREQ_W);
        div_den   = RATE_DEN;
        if (div_sts.done) begin
          phase_nxt = phase_r + div_quo;
          state_nxt = S_INDEX;
          kick_nxt  = 1'b1;
        end
      end
      S_INDEX: begin
        mul_start = kick_r;
        mul_a     = MUL_A_W'(phase_r);
        mul_b     = QUAD_SCALE;
        if (mul_sts.done) begin
          j_nxt     = j_calc;
          neg_nxt   = quad[1];
          state_nxt = S_ANGLE_MUL;
          kick_nxt  = 1'b1;
        end
      end
      S_ANGLE_MUL: begin
        mul_start = kick_r;
        mul_a     = Q30_HALF_PI;
        mul_b     = MUL_B_W'(j_r);
        if (mul_sts.done) begin
          state_nxt = S_ANGLE_DIV;
          kick_nxt  = 1'b1;
        end
      end
      S_ANGLE_DIV: begin
        div_start = kick_r;
        div_num   = {mul_prod[ANGLE_W-1:0], {(DIV_N_W-ANGLE_W){1'b0}}};
        div_steps = DIV_CNT_W'(ANGLE_W);
        div_den   = DEPTH_DEN;
        if (div_sts.done) begin
          x_nxt     = div_quo[X_W-1:0];
          state_nxt = S_SQUARE;
          kick_nxt  = 1'b1;
        end
      end
      S_SQUARE: begin
        mul_start = kick_r;
        mul_a     = MUL_A_W'(x_r);
        mul_b     = MUL_B_W'(x_r);
        if (mul_sts.done) begin
          x2_nxt     = mul_prod[Q30_SH+X2_W-1:Q30_SH];
          dvd_nxt    = mul_prod[Q30_SH+X2_W-1:Q30_SH];
          term_k_nxt = '0;
          state_nxt  = S_TERM_DIV;
          kick_nxt   = 1'b1;
        end
      end
      S_TERM_DIV: begin
        div_start = kick_r;
        div_num   = {dvd_r, {(DIV_N_W-X2_W){1'b0}}};
        div_steps = DIV_CNT_W'(X2_W);
        div_den   = term_den(term_k_r);
        if (div_sts.done) begin
          t_nxt    = Q30_ONE - div_quo[T_W-1:0];
          kick_nxt = 1'b1;
          if (term_k_r == TERM_LAST) begin
            state_nxt = S_SINE;
          end else begin
            term_k_nxt = term_k_r + 1'b1;
            state_nxt  = S_TERM_MUL;
          end
        end
      end
      S_TERM_MUL: begin
        mul_start = kick_r;
        mul_a     = MUL_A_W'(x2_r);
        mul_b     = MUL_B_W'(t_r);
        if (mul_sts.done) begin
          dvd_nxt   = mul_prod[Q30_SH+X2_W-1:Q30_SH];
          state_nxt = S_TERM_DIV;
          kick_nxt  = 1'b1;
        end
      end
      S_SINE: begin
        mul_start = kick_r;
        mul_a     = MUL_A_W'(x_r);
        mul_b     = MUL_B_W'(t_r);
        if (mul_sts.done) begin
          rom_nxt   = rom_calc;
          state_nxt = S_AMP;
          kick_nxt  = 1'b1;
        end
      end
      S_AMP: begin
        mul_start = kick_r;
        mul_a     = MUL_A_W'(rom_r);
        mul_b     = MUL_B_W'(amp_r);
        if (mul_sts.done) begin
          state_nxt = S_ENV;
          kick_nxt  = 1'b1;
        end
      end
      S_ENV: begin
        mul_start = kick_r;
        mul_a     = mul_prod;
        mul_b     = fade_r ? MUL_B_W'(env_r) : MUL_B_W'(ENV_ONE);
        if (mul_sts.done) begin
          state_nxt = S_SCALE;
          kick_nxt  = 1'b1;
        end
      end
      S_SCALE: begin
        mul_start = kick_r;
        mul_a     = mul_prod;
        mul_b     = MAX_MULT;
        if (mul_sts.done) begin
          mag_nxt   = mul_prod[MAG_LSB+SAMPLE_W-1:MAG_LSB];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold here until the output register frees
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = signed'(sample_bits);
          out_last_nxt   = last_calc;
          if (fade_r) begin
            env_nxt = env_calc;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (last_calc) begin
            active_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kick_r      <= 1'b0;
      freq_r      <= '0;
      amp_r       <= '0;
      len_r       <= '0;
      fade_r      <= 1'b0;
      phase_r     <= '0;
      cnt_r       <= '0;
      env_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kick_r      <= kick_nxt;
      freq_r      <= freq_nxt;
      amp_r       <= amp_nxt;
      len_r       <= len_nxt;
      fade_r      <= fade_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      env_r       <= env_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    total_r      <= total_nxt;
    j_r          <= j_nxt;
    neg_r        <= neg_nxt;
    x_r          <= x_nxt;
    x2_r         <= x2_nxt;
    dvd_r        <= dvd_nxt;
    t_r          <= t_nxt;
    rom_r        <= rom_nxt;
    term_k_r     <= term_k_nxt;
    mag_r        <= mag_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign cfg_chan.ready       = 1'b1;
  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.sample_value = out_sample_r;
  assign out_chan.last_of_tone = out_last_r;

  `FSTG_ASSERT(a_units_exclusive, !(mul_sts.busy && div_sts.busy), "multiplier and divider busy together")
  `FSTG_ASSERT(a_env_bound, env_r <= ENV_ONE, "envelope above unity")
  `FSTG_ASSERT_NEXT(a_tone_holds, active_r && (state_r != S_TOTAL) && !((state_r == S_EMIT) && out_free && last_calc), active_r, "tone stopped without its last word")

endmodule
